### rtl/oscillator_crossing_timestamper_defines.svh
// Assertion macros for the oscillator crossing timestamper.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef OSCILLATOR_CROSSING_TIMESTAMPER_DEFINES_SVH
`define OSCILLATOR_CROSSING_TIMESTAMPER_DEFINES_SVH

// same-cycle implication, masked during reset
`define OCT_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset too
`define OCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/oct_pkg.sv
// Shared types, constants and the quarter-wave sine generator.
// No dependencies; imported by every module of the timestamper.
package oct_pkg;

   localparam int          SINE_W      = 16;
   localparam int          SINE_PEAK   = 32767;
   localparam int          PERIOD_W    = 32;
   localparam int          TIME_W      = 64;
   localparam int          CHUNK_W     = 16;
   localparam int          WRAP_RAD    = 6;
   localparam int          QUEUE_DEPTH = 4;
   localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CSR_MODE          = 2'd0,
      CSR_SAMPLE_PERIOD = 2'd1,
      CSR_STAMP_START   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                mode;
      logic [PERIOD_W-1:0] sample_period;
      logic                stamp_start;
   } cfg_type;

   typedef enum logic [4:0] {
      B_IDLE      = 5'b00001,
      B_DIVIDE    = 5'b00010,
      B_FRAC_MUL  = 5'b00100,
      B_INDEX_MUL = 5'b01000,
      B_EMIT      = 5'b10000
   } back_state_type;

   // Taylor series of sin(x), x in Q30, result Q15 rounded; elaboration only
   function automatic logic [15:0] q15_sine(input logic [63:0] x);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] prod;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
         prod = (((term * x) >> 30) * x) >> 30;
         case (n)
            1: term = prod / 6;
            2: term = prod / 20;
            3: term = prod / 42;
            4: term = prod / 72;
            5: term = prod / 110;
            default: term = prod / 156;
         endcase
         if (n % 2 == 1) begin
            sum = (sum > term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + 64'd16384) >> 15;
      return (sum > 64'(SINE_PEAK)) ? 16'(SINE_PEAK) : sum[15:0];
   endfunction

endpackage

### rtl/oct_front.sv
// Front end: sine lookup pipeline and crossing classifier.
// Depends on oct_pkg; pushes crossing jobs into oct_queue.
module oct_front #(
   parameter int PHASE_FRAC_BITS  = 13,
   parameter int INDEX_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int NUM_W            = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  oct_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PHASE_FRAC_BITS+2:0] req_phase,
   input  logic                       req_first_sample,
   input  logic                       job_full,
   output logic                       job_push,
   output logic [INDEX_BITS-1:0]      job_index,
   output logic [NUM_W-1:0]           job_num,
   output logic [NUM_W:0]             job_den,
   output logic                       job_fresh
);
   import oct_pkg::*;

   localparam int          PW     = PHASE_FRAC_BITS + 3;
   localparam int          L      = $clog2(SINE_TABLE_DEPTH);
   localparam int          PSH    = L + 2;
   localparam int          XW     = PW + PSH;
   localparam int          SH     = PW + PSH + 1;
   localparam int          AW     = SINE_W + 1;
   localparam int          MW     = SINE_W - 1;
   localparam logic [63:0] TWO_PI = (TWO_PI_Q32 + (64'd1 << (31 - PHASE_FRAC_BITS)))
                                    >> (32 - PHASE_FRAC_BITS);
   localparam logic [63:0] WRAP   = 64'(WRAP_RAD) << PHASE_FRAC_BITS;
   localparam logic [63:0] RECIP  = (64'd1 << SH) / TWO_PI;
   localparam int          RW     = $clog2(RECIP + 64'd1);
   localparam logic [L:0]  DEPTH_V = (L + 1)'(SINE_TABLE_DEPTH);

   // quarter-wave table, constant per entry
   logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      assign sine_rom[g] = q15_sine((HALF_PI_Q30 * 64'(g)) / SINE_TABLE_DEPTH);
   end

   logic adv;
   assign adv       = !job_full;
   assign req_ready = adv;

   // stage 1: reduce, reciprocal multiply
   logic s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_phase_ff;
   logic s1_first_ff;
   logic [PW-1:0] s1_red;
   logic [PW+RW-1:0] s1_prod;

   assign s1_valid_in = req_valid;
   assign s1_red  = (s1_phase_ff >= PW'(TWO_PI)) ? s1_phase_ff - PW'(TWO_PI) : s1_phase_ff;
   assign s1_prod = (PW + RW)'(s1_red) * (PW + RW)'(RECIP[RW-1:0]);

   // stage 2: quotient estimate correction
   logic s2_valid_ff;
   logic [PW-1:0] s2_phase_ff, s2_red_ff;
   logic s2_first_ff;
   logic [PW+RW-1:0] s2_prod_ff;
   logic [PSH:0] s2_est, s2_next, s2_p;
   logic [XW:0] s2_scaled, s2_bound;

   assign s2_est    = (PSH + 1)'(s2_prod_ff >> (SH - PSH));
   assign s2_next   = s2_est + 1'b1;
   assign s2_bound  = (XW + 1)'(s2_next) * (XW + 1)'(TWO_PI);
   assign s2_scaled = (XW + 1)'({s2_red_ff, {PSH{1'b0}}});
   assign s2_p      = (s2_bound <= s2_scaled) ? s2_next : s2_est;

   // stage 3: quadrant and table address
   logic s3_valid_ff;
   logic [PW-1:0] s3_phase_ff;
   logic s3_first_ff;
   logic [1:0] s3_quad_ff;
   logic [L-1:0] s3_k_ff, s3_addr;
   logic s3_peak;

   assign s3_peak = s3_quad_ff[0] && (s3_k_ff == '0);
   assign s3_addr = s3_quad_ff[0] ? L'(DEPTH_V - {1'b0, s3_k_ff}) : s3_k_ff;

   // stage 4: signed amplitude and classification
   logic s4_valid_ff;
   logic [PW-1:0] s4_phase_ff;
   logic s4_first_ff, s4_neg_ff, s4_peak_ff;
   logic [SINE_W-1:0] s4_rom_ff, s4_mag;
   logic signed [AW-1:0] s4_amp;

   assign s4_mag = s4_peak_ff ? SINE_W'(SINE_PEAK) : s4_rom_ff;
   assign s4_amp = s4_neg_ff ? -$signed({1'b0, s4_mag}) : $signed({1'b0, s4_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_phase_ff <= req_phase;
         s1_first_ff <= req_first_sample;
         s2_phase_ff <= s1_phase_ff;
         s2_first_ff <= s1_first_ff;
         s2_red_ff   <= s1_red;
         s2_prod_ff  <= s1_prod;
         s3_phase_ff <= s2_phase_ff;
         s3_first_ff <= s2_first_ff;
         s3_quad_ff  <= s2_p[PSH-1:L];
         s3_k_ff     <= s2_p[L-1:0];
         s4_phase_ff <= s3_phase_ff;
         s4_first_ff <= s3_first_ff;
         s4_neg_ff   <= s3_quad_ff[1];
         s4_peak_ff  <= s3_peak;
         s4_rom_ff   <= sine_rom[s3_addr];
      end
   end

   // series state
   logic [PW-1:0] last_phase_ff;
   logic signed [AW-1:0] last_amp_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic have_ff, parity_ff, fresh_ff;

   logic start, wrap, change, keep, crossing;
   logic [PW-1:0] diff;
   logic [NUM_W-1:0] pnum, mnum;
   logic [NUM_W:0] pden, mden;
   logic [MW-1:0] m1, m2;

   assign start  = s4_first_ff || !have_ff;
   assign diff   = (last_phase_ff > s4_phase_ff) ? last_phase_ff - s4_phase_ff
                                                 : s4_phase_ff - last_phase_ff;
   assign wrap   = diff > PW'(WRAP);
   assign pnum   = (PW'(TWO_PI) > last_phase_ff) ? NUM_W'(PW'(TWO_PI) - last_phase_ff) : '0;
   assign pden   = (NUM_W + 1)'(pnum) + (NUM_W + 1)'(s4_phase_ff);
   assign change = (last_amp_ff > 0 && s4_amp < 0) || (last_amp_ff < 0 && s4_amp > 0);
   assign m1     = MW'(last_amp_ff < 0 ? -last_amp_ff : last_amp_ff);
   assign m2     = MW'(s4_amp < 0 ? -s4_amp : s4_amp);
   assign mnum   = NUM_W'(m1);
   assign mden   = (NUM_W + 1)'(m1) + (NUM_W + 1)'(m2);
   assign keep   = parity_ff == cfg.stamp_start;
   assign crossing = cfg.mode ? wrap : (change && keep);

   assign job_push  = s4_valid_ff && adv && !start && crossing;
   assign job_index = index_ff;
   assign job_num   = cfg.mode ? pnum : mnum;
   assign job_den   = cfg.mode ? pden : mden;
   assign job_fresh = fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff   <= 1'b0;
         parity_ff <= 1'b0;
         fresh_ff  <= 1'b1;
         index_ff  <= '0;
      end else if (s4_valid_ff && adv) begin
         if (start) begin
            have_ff   <= 1'b1;
            parity_ff <= 1'b0;
            fresh_ff  <= 1'b1;
            index_ff  <= '0;
         end else begin
            index_ff <= index_ff + 1'b1;
            if (!cfg.mode && change) begin
               parity_ff <= !parity_ff;
            end
            if (job_push) begin
               fresh_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid_ff && adv) begin
         last_phase_ff <= s4_phase_ff;
         last_amp_ff   <= s4_amp;
      end
   end

endmodule

### rtl/oct_queue.sv
// Small job queue between front and back ends.
// Imports oct_pkg; the top level sets the depth from its QUEUE_DEPTH.
module oct_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   import oct_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/oct_back.sv
// Back end: bit-serial fraction divider, time multiply, gap and output word.
// Depends on oct_pkg; pops jobs from oct_queue.
module oct_back #(
   parameter int INDEX_BITS      = 32,
   parameter int CROSS_FRAC_BITS = 16,
   parameter int NUM_W           = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  oct_pkg::cfg_type      cfg,
   input  logic                  job_valid,
   output logic                  job_pop,
   input  logic [INDEX_BITS-1:0] job_index,
   input  logic [NUM_W-1:0]      job_num,
   input  logic [NUM_W:0]        job_den,
   input  logic                  job_fresh,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_event_time,
   output logic [63:0]           rsp_gap_time,
   output logic                  rsp_gap_valid
);
   import oct_pkg::*;

   localparam int C      = CROSS_FRAC_BITS;
   localparam int STEP_W = $clog2(C + 1);
   localparam int CHUNKS = (INDEX_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int JW     = CHUNKS * CHUNK_W;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int RMW    = NUM_W + 2;

   back_state_type state_ff, state_in;
   logic [JW-1:0] j_ff;
   logic [NUM_W:0] den_ff;
   logic [RMW-1:0] rem_ff;
   logic [C:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CW-1:0] chunk_ff;
   logic zero_ff, fresh_ff;
   logic [TIME_W-1:0] frac_ff, jacc_ff, last_ff;
   logic rsp_valid_ff;
   logic [TIME_W-1:0] event_ff, gap_ff;
   logic gap_valid_ff;

   logic ge;
   logic [RMW-1:0] rem_sub;
   logic [C+PERIOD_W:0] frac_prod;
   logic [CHUNK_W+PERIOD_W-1:0] chunk_prod;
   logic [TIME_W-1:0] t;
   logic out_free;

   assign ge         = rem_ff >= RMW'(den_ff);
   assign rem_sub    = ge ? rem_ff - RMW'(den_ff) : rem_ff;
   assign frac_prod  = (C + PERIOD_W + 1)'(zero_ff ? '0 : quo_ff)
                       * (C + PERIOD_W + 1)'(cfg.sample_period);
   assign chunk_prod = (CHUNK_W + PERIOD_W)'(j_ff[JW-1 -: CHUNK_W])
                       * (CHUNK_W + PERIOD_W)'(cfg.sample_period);
   assign t          = jacc_ff + frac_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign job_pop    = (state_ff == B_IDLE) && job_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:      if (job_valid) state_in = B_DIVIDE;
         B_DIVIDE:    if (step_ff == STEP_W'(C)) state_in = B_FRAC_MUL;
         B_FRAC_MUL:  state_in = B_INDEX_MUL;
         B_INDEX_MUL: if (chunk_ff == '0) state_in = B_EMIT;
         B_EMIT:      if (out_free) state_in = B_IDLE;
         default:     state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            j_ff     <= JW'(job_index);
            den_ff   <= job_den;
            rem_ff   <= RMW'(job_num);
            zero_ff  <= job_den == '0;
            fresh_ff <= job_fresh;
            step_ff  <= '0;
            quo_ff   <= '0;
         end
         B_DIVIDE: begin
            rem_ff  <= {rem_sub[RMW-2:0], 1'b0};
            quo_ff  <= {quo_ff[C-1:0], ge};
            step_ff <= step_ff + 1'b1;
         end
         B_FRAC_MUL: begin
            frac_ff  <= TIME_W'(frac_prod >> C);
            jacc_ff  <= '0;
            chunk_ff <= CW'(CHUNKS - 1);
         end
         B_INDEX_MUL: begin
            // Horner over 16-bit digits of the index, top digit first
            jacc_ff  <= (jacc_ff << CHUNK_W) + TIME_W'(chunk_prod);
            j_ff     <= j_ff << CHUNK_W;
            chunk_ff <= chunk_ff - 1'b1;
         end
         B_EMIT: begin
            if (out_free) begin
               event_ff     <= t;
               gap_ff       <= fresh_ff ? '0 : t - last_ff;
               gap_valid_ff <= !fresh_ff;
               last_ff      <= t;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_time = event_ff;
   assign rsp_gap_time   = gap_ff;
   assign rsp_gap_valid  = gap_valid_ff;

endmodule

### rtl/oscillator_crossing_timestamper.sv
// Oscillator crossing timestamper: CSR block, front end, job queue, back end.
// Depends on oct_pkg, oct_front, oct_queue, oct_back and the defines header.
//
// Usage:
//   req_ channel: one phase sample per word (req_phase, req_first_sample).
//     req_ready is high whenever the job queue has room, so samples stream
//     at one word per cycle while crossings stay sparse.
//   rsp_ channel: one word per kept crossing (event time, gap, gap_valid).
//   csr_ channel: index/data writes, always ready; write only while idle.
// Datapath: the front pipeline reduces the phase, corrects the quotient, forms the
//   table address, then does the table lookup and classifies; the back end takes each
//   crossing through idle, bit-serial divide, fraction multiply, index multiply and emit.
// Throughput: samples at 1 per cycle; crossings at one per back-end pass.
//   A 4-word queue absorbs bursts; when it fills, req_ready drops.
// Reset: synchronous; config returns to phase mode, dt = 1.0, start 0;
//   the series is cleared and the first sample after reset opens one.
// Receiver stall: the result waits in the output register; the back end
//   finishes its next job and holds it, then the queue and front fill.
`include "oscillator_crossing_timestamper_defines.svh"

module oscillator_crossing_timestamper #(
   parameter int PHASE_FRAC_BITS  = 13,
   parameter int INDEX_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int CROSS_FRAC_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PHASE_FRAC_BITS+2:0] req_phase,
   input  logic                       req_first_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [63:0]                rsp_event_time,
   output logic [63:0]                rsp_gap_time,
   output logic                       rsp_gap_valid
);
   import oct_pkg::*;

   localparam int PW    = PHASE_FRAC_BITS + 3;
   localparam int NUM_W = (PW > SINE_W - 1) ? PW : SINE_W - 1;
   localparam int JOB_W = INDEX_BITS + NUM_W + (NUM_W + 1) + 1;

   // configuration registers
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= 1'b1;
         cfg_ff.sample_period <= 32'd16777216;
         cfg_ff.stamp_start   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:          cfg_ff.mode          <= csr_data[0];
            CSR_SAMPLE_PERIOD: cfg_ff.sample_period <= csr_data;
            CSR_STAMP_START:   cfg_ff.stamp_start   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // front -> queue
   logic                  job_push, job_full, job_fresh;
   logic [INDEX_BITS-1:0] job_index;
   logic [NUM_W-1:0]      job_num;
   logic [NUM_W:0]        job_den;
   logic [JOB_W-1:0]      job_in, job_out;

   // queue -> back
   logic                  job_valid, job_pop;

   oct_front #(
      .PHASE_FRAC_BITS  (PHASE_FRAC_BITS),
      .INDEX_BITS       (INDEX_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .NUM_W            (NUM_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_phase        (req_phase),
      .req_first_sample (req_first_sample),
      .job_full         (job_full),
      .job_push         (job_push),
      .job_index        (job_index),
      .job_num          (job_num),
      .job_den          (job_den),
      .job_fresh        (job_fresh)
   );

   assign job_in = {job_index, job_num, job_den, job_fresh};

   oct_queue #(
      .WIDTH     (JOB_W),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .pop_data  (job_out)
   );

   oct_back #(
      .INDEX_BITS      (INDEX_BITS),
      .CROSS_FRAC_BITS (CROSS_FRAC_BITS),
      .NUM_W           (NUM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .job_valid       (job_valid),
      .job_pop         (job_pop),
      .job_index       (job_out[JOB_W-1 -: INDEX_BITS]),
      .job_num         (job_out[2*NUM_W+1 -: NUM_W]),
      .job_den         (job_out[NUM_W+1:1]),
      .job_fresh       (job_out[0]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_time  (rsp_event_time),
      .rsp_gap_time    (rsp_gap_time),
      .rsp_gap_valid   (rsp_gap_valid)
   );

   // first event of a series carries no gap
   `OCT_ASSERT_HOLDS(a_gap_zero, rsp_valid && !rsp_gap_valid, rsp_gap_time == 64'd0, "gap without prior event")
   // back end never pops an empty queue
   `OCT_ASSERT_HOLDS(a_pop_valid, job_pop, job_valid, "pop from empty job queue")
   // no result word survives reset
   `OCT_ASSERT_NEXT(a_reset_clear, reset, !rsp_valid, "result valid after reset")

endmodule
